>>> hdl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        error;
    } t_out_item;

    // front-to-back command: one word to load, plus flags
    typedef struct packed {
        logic [31:0] word;
        logic        finish;   // pad and emit digest after this word
        logic        err;      // short non-final item, emit error result
        logic [2:0]  count;    // valid bytes when finish
    } t_cmd;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [31:0] IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

    localparam logic [31:0] RK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> hdl/sha_front.sv
`timescale 1ns / 1ps
module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sha_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output sha_pkg::t_cmd     o_cmd
);
    import sha_pkg::*;

    t_cmd            r_q [QDEPTH];
    logic [QAW-1:0]  r_wp, r_rp;
    logic [QAW:0]    r_cnt;
    t_cmd            w_cmd;
    logic [2:0]      w_cnt;
    logic [31:0]     w_keep;
    logic            w_push, w_pop;

    // classify the incoming transaction
    always_comb begin
        w_cnt  = (i_item.byte_count > 3'd4) ? 3'd4 : i_item.byte_count;
        w_keep = 32'hFFFF_FFFF << (6'd8 * (6'd4 - {3'd0, w_cnt}));
        if (w_cnt == 3'd0) w_keep = '0;
        w_cmd.finish = i_item.end_of_message;
        w_cmd.err    = !i_item.end_of_message && (w_cnt != 3'd4);
        w_cmd.count  = w_cnt;
        w_cmd.word   = i_item.end_of_message ? (i_item.data_word & w_keep) : i_item.data_word;
    end

    assign o_ready     = (r_cnt != QDEPTH[QAW:0]);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    // command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{QAW{1'b0}}, w_push} - {{QAW{1'b0}}, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule

>>> hdl/sha_back.sv
`timescale 1ns / 1ps
module sha_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  sha_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_item o_item
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_COMP = 3'd2,
                           S_OUT = 3'd3, S_ERR = 3'd4;

    logic [2:0]   r_st;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [3:0]   r_fill;
    logic [60:0]  r_bytes;
    logic [5:0]   r_rnd;
    logic         r_fin;      // padding in progress
    logic         r_lenin;    // length words are in the current block
    logic [1:0]   r_padph;    // 0 marker pending, 1 zeros, 2 len hi, 3 len lo
    logic [2:0]   r_oi;
    logic [31:0]  w_word;
    logic         w_load;
    logic [31:0]  w_t1, w_t2, w_s0, w_s1, w_new;
    logic [31:0]  w_nv [8];
    logic [63:0]  w_bits;

    assign w_bits = {r_bytes, 3'b000};

    // round and schedule logic
    always_comb begin
        w_t1 = r_v[7] + (rotr(r_v[4],6) ^ rotr(r_v[4],11) ^ rotr(r_v[4],25))
             + (r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6]))) + RK[r_rnd] + r_w[0];
        w_t2 = (rotr(r_v[0],2) ^ rotr(r_v[0],13) ^ rotr(r_v[0],22))
             + ((r_v[0] & r_v[1]) | (r_v[2] & (r_v[0] | r_v[1])));
        w_s0 = rotr(r_w[1],7) ^ rotr(r_w[1],18) ^ (r_w[1] >> 3);
        w_s1 = rotr(r_w[14],17) ^ rotr(r_w[14],19) ^ (r_w[14] >> 10);
        w_new = w_s1 + r_w[9] + w_s0 + r_w[0];
    end

    // working variables after this round
    always_comb begin
        w_nv[0] = w_t1 + w_t2;
        w_nv[1] = r_v[0];
        w_nv[2] = r_v[1];
        w_nv[3] = r_v[2];
        w_nv[4] = r_v[3] + w_t1;
        w_nv[5] = r_v[4];
        w_nv[6] = r_v[5];
        w_nv[7] = r_v[6];
    end

    // word source during padding
    always_comb begin
        w_load = 1'b0;
        w_word = '0;
        if (r_st == S_PAD) begin
            unique case (r_padph)
                2'd0: begin w_word = 32'h8000_0000; w_load = 1'b1; end
                2'd1: begin
                    w_word = '0;
                    w_load = (r_fill != 4'd14);
                end
                2'd2: begin w_word = w_bits[63:32]; w_load = 1'b1; end
                default: begin w_word = w_bits[31:0]; w_load = 1'b1; end
            endcase
        end
    end

    assign o_cmd_ready = (r_st == S_IDLE);
    assign o_valid     = (r_st == S_OUT) || (r_st == S_ERR);
    always_comb begin
        o_item = '0;
        if (r_st == S_ERR) begin
            o_item.last_word = 1'b1;
            o_item.error     = 1'b1;
        end else begin
            o_item.digest_word = r_h[r_oi];
            o_item.word_index  = r_oi;
            o_item.last_word   = (r_oi == 3'd7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_fill <= '0; r_bytes <= '0; r_fin <= 1'b0;
            r_lenin <= 1'b0; r_padph <= '0; r_oi <= '0; r_rnd <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else begin
            unique case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    if (i_cmd.err) r_st <= S_ERR;
                    else if (i_cmd.finish && i_cmd.count != 3'd4) begin
                        // partial final word carries the marker byte
                        r_w[r_fill] <= i_cmd.word | (32'h80 << (6'd8 * (6'd3 - {3'd0, i_cmd.count})));
                        r_bytes <= r_bytes + {58'd0, i_cmd.count};
                        r_fin <= 1'b1; r_padph <= 2'd1;
                        r_fill <= r_fill + 1'b1;
                        r_st <= (r_fill == 4'd15) ? S_COMP : S_PAD;
                    end else begin
                        r_w[r_fill] <= i_cmd.word;
                        r_bytes <= r_bytes + 61'd4;
                        r_fin <= i_cmd.finish; r_padph <= 2'd0;
                        r_fill <= r_fill + 1'b1;
                        r_st <= (r_fill == 4'd15) ? S_COMP :
                                (i_cmd.finish ? S_PAD : S_IDLE);
                    end
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd <= '0;
                end
                S_PAD: begin
                    if (w_load) begin
                        r_w[r_fill] <= w_word;
                        r_fill <= r_fill + 1'b1;
                        if (r_fill == 4'd15) r_st <= S_COMP;
                    end
                    // advance through marker, zeros and length words
                    unique case (r_padph)
                        2'd0: r_padph <= 2'd1;
                        2'd1: if (r_fill == 4'd14) r_padph <= 2'd2;
                        2'd2: r_padph <= 2'd3;
                        default: r_lenin <= 1'b1;
                    endcase
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd <= '0;
                end
                S_COMP: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= w_nv[i];
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_rnd <= r_rnd + 1'b1;
                    if (r_rnd == 6'd63) begin
                        for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + w_nv[i];
                        // digest ready once the block with the length is done
                        if (r_lenin) r_st <= S_OUT;
                        else if (r_fin) r_st <= S_PAD;
                        else r_st <= S_IDLE;
                        r_oi <= '0;
                    end
                end
                S_OUT: if (i_ready) begin
                    r_oi <= r_oi + 1'b1;
                    if (r_oi == 3'd7) begin
                        r_st <= S_IDLE; r_fin <= 1'b0; r_lenin <= 1'b0;
                        r_bytes <= '0; r_fill <= '0;
                        for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
                    end
                end
                S_ERR: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// an accepted transaction is queued in the front end; the back end loads one word a
// cycle while idle, and each full 16-word block is then compressed in 64 rounds, during
// which it takes no new word; the front queue holds up to 4 transactions meanwhile
// final item: marker, zero and length words, one or two compressions, then 8 digest words
// throughput is set by the single shared round unit in the back end
// reset: synchronous active low, restores the initial hash values and empties the queue
module sha256_stream_hasher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_item o_data
);
    import sha_pkg::*;

    t_cmd w_cmd;
    logic w_cv, w_cr;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(i_data),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd));

    sha_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .o_valid, .i_ready, .o_item(o_data));
endmodule

>>> hdl/sha_checker.sv
`timescale 1ns / 1ps
module sha_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input sha_pkg::t_out_item o_data
);
    import sha_pkg::*;

    // error results always close their own transaction
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error |-> o_data.last_word && o_data.word_index == 3'd0)
        else $error("error result malformed");

    // digest word index advances by one
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.error && !o_data.last_word |=>
        o_valid && o_data.word_index == $past(o_data.word_index) + 3'd1)
        else $error("digest index skipped");

    // last word only on index seven for digests
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.error |-> (o_data.last_word == (o_data.word_index == 3'd7)))
        else $error("last flag misplaced");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed under stall");
endmodule

bind sha256_stream_hasher_unit sha_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data);
